[src/lrsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrsa_pkg
// Shared types, constants and elaboration-time tables of the LED ring
// status animator.
// ----------------------------------------------------------------------------
package lrsa_pkg;

    localparam int RING_LEDS_DEFAULT = 24;

    localparam int IDX_W   = 6;
    localparam int COLOR_W = 8;
    localparam int MODE_W  = 3;
    localparam int TICKS_W = 7;
    localparam int LEVEL_W = 8;
    localparam int LIT_W   = 7;
    localparam int PHASE_W = 7;

    localparam logic [TICKS_W-1:0] OVERLAY_TICKS_RESET = 7'd75;

    localparam logic [COLOR_W-1:0] BOOT_LEVEL_0   = 8'd80;
    localparam logic [COLOR_W-1:0] BOOT_LEVEL_1   = 8'd35;
    localparam logic [COLOR_W-1:0] BOOT_LEVEL_2   = 8'd10;
    localparam logic [COLOR_W-1:0] STREAM_LEVEL_0 = 8'd60;
    localparam logic [COLOR_W-1:0] STREAM_LEVEL_1 = 8'd30;
    localparam logic [COLOR_W-1:0] STREAM_LEVEL_2 = 8'd10;
    localparam logic [COLOR_W-1:0] BAR_LEVEL      = 8'd60;
    localparam logic [COLOR_W-1:0] MUTE_LEVEL     = 8'd12;
    localparam logic [COLOR_W-1:0] ERROR_LEVEL    = 8'd80;

    localparam int BOOT_STEP     = 6;
    localparam int ERROR_STEP    = 10;
    localparam int STREAM_PERIOD = 80;
    localparam int WAKE_PERIOD   = 100;
    localparam int SPEAK_PERIOD  = 120;
    localparam int CAPT_PERIOD   = 75;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [MODE_W-1:0] {
        MODE_BOOT,
        MODE_IDLE,
        MODE_WAKE,
        MODE_STREAM,
        MODE_SPEAK,
        MODE_MUTE,
        MODE_ERROR,
        MODE_CAPTURE
    } t_mode;

    typedef enum logic [1:0] {
        PULSE_WAKE,
        PULSE_SPEAK,
        PULSE_CAPT_RED,
        PULSE_CAPT_BLUE
    } t_pulse;

    typedef struct packed {
        logic [MODE_W-1:0]  display_mode;
        logic               volume_request;
        logic [LEVEL_W-1:0] volume_percent;
    } t_tick;

    typedef struct packed {
        logic [IDX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               frame_last;
    } t_pixel;

    typedef logic [TICKS_W-1:0] t_cfg;

    typedef logic [127:0][COLOR_W-1:0]          t_pulse_rom;
    typedef logic [255:0][LIT_W-1:0]            t_lit_rom;
    typedef logic [STREAM_PERIOD-1:0][IDX_W-1:0] t_stream_rom;

    function automatic logic [63:0] div_period(logic [63:0] v, t_pulse sel);
        case (sel)
            PULSE_WAKE:  return v / 64'd100;
            PULSE_SPEAK: return v / 64'd120;
            default:     return v / 64'd75;
        endcase
    endfunction

    function automatic logic [63:0] period_of(t_pulse sel);
        case (sel)
            PULSE_WAKE:  return 64'(WAKE_PERIOD);
            PULSE_SPEAK: return 64'(SPEAK_PERIOD);
            default:     return 64'(CAPT_PERIOD);
        endcase
    endfunction

    // taylor term divisors, sine (2n)(2n+1) and cosine (2n-1)(2n)
    function automatic logic [63:0] term_div(logic [63:0] t, logic [2:0] n, logic odd);
        if (odd) begin
            case (n)
                3'd1:    return t / 64'd6;
                3'd2:    return t / 64'd20;
                3'd3:    return t / 64'd42;
                3'd4:    return t / 64'd72;
                3'd5:    return t / 64'd110;
                3'd6:    return t / 64'd156;
                default: return t / 64'd210;
            endcase
        end else begin
            case (n)
                3'd1:    return t / 64'd2;
                3'd2:    return t / 64'd12;
                3'd3:    return t / 64'd30;
                3'd4:    return t / 64'd56;
                3'd5:    return t / 64'd90;
                3'd6:    return t / 64'd132;
                default: return t / 64'd182;
            endcase
        end
    endfunction

    function automatic logic [63:0] series_q30(logic [63:0] x, logic odd);
        logic [63:0] x2;
        logic [63:0] t;
        longint      sum;
        x2  = (x * x) >> 30;
        t   = odd ? x : Q30_ONE;
        sum = longint'(t);
        for (int n = 1; n <= 7; n++) begin
            t = term_div((t * x2) >> 30, 3'(n), odd);
            if ((n & 1) == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(Q30_ONE)) begin
            sum = longint'(Q30_ONE);
        end
        return 64'(sum);
    endfunction

    function automatic longint sine_q30(logic [63:0] k, t_pulse sel);
        logic [63:0] q;
        logic [63:0] quad;
        logic [63:0] r;
        logic        use_sin;
        longint      mag;
        q       = 64'd4 * k;
        quad    = div_period(q, sel);
        r       = q - quad * period_of(sel);
        use_sin = (quad[0] == 1'b0);
        if (r == 64'd0) begin
            mag = use_sin ? 0 : longint'(Q30_ONE);
        end else begin
            mag = longint'(series_q30(div_period(HALF_PI_Q30 * r, sel), use_sin));
        end
        return (quad >= 64'd2) ? -mag : mag;
    endfunction

    function automatic logic [COLOR_W-1:0] pulse_entry(logic [63:0] k, t_pulse sel);
        longint a;
        longint b;
        longint s;
        longint v;
        case (sel)
            PULSE_WAKE:     begin a = 20; b = 60; end
            PULSE_SPEAK:    begin a = 15; b = 55; end
            PULSE_CAPT_RED: begin a = 5;  b = 25; end
            default:        begin a = 25; b = 35; end
        endcase
        s = sine_q30(k, sel);
        v = ((2 * a + b) <<< 30) + b * s;
        if (v < 0) begin
            v = 0;
        end
        return COLOR_W'(v >>> 31);
    endfunction

    function automatic t_pulse_rom build_pulse_rom(t_pulse sel);
        t_pulse_rom rom;
        for (int k = 0; k < 128; k++) begin
            if (64'(k) < period_of(sel)) begin
                rom[k] = pulse_entry(64'(k), sel);
            end else begin
                rom[k] = '0;
            end
        end
        return rom;
    endfunction

    function automatic t_lit_rom build_lit_rom(int n);
        t_lit_rom rom;
        int       v;
        for (int lv = 0; lv < 256; lv++) begin
            v = (lv * n + 50) / 100;
            if (v > n) begin
                v = n;
            end
            rom[lv] = LIT_W'(v);
        end
        return rom;
    endfunction

    function automatic t_stream_rom build_stream_rom(int n);
        t_stream_rom rom;
        for (int m = 0; m < STREAM_PERIOD; m++) begin
            rom[m] = IDX_W'((m * n) / STREAM_PERIOD);
        end
        return rom;
    endfunction

    localparam t_pulse_rom WAKE_ROM      = build_pulse_rom(PULSE_WAKE);
    localparam t_pulse_rom SPEAK_ROM     = build_pulse_rom(PULSE_SPEAK);
    localparam t_pulse_rom CAPT_RED_ROM  = build_pulse_rom(PULSE_CAPT_RED);
    localparam t_pulse_rom CAPT_BLUE_ROM = build_pulse_rom(PULSE_CAPT_BLUE);

endpackage
`default_nettype wire

[src/lrsa_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrsa_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lrsa_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[src/led_ring_status_animator.sv]
// path: pixel 0 of a tick is registered first in the frame descriptor r_cur, then in r_out
// flow: one pixel a cycle through the single output register while o_pixel is
//   not stalled; the next tick is taken as the last pixel enters it
// reset: synchronous active low, clears frame phases, overlay and output,
//   mode to boot, overlay_ticks to 75; no memory clearing pass
`default_nettype none
// ----------------------------------------------------------------------------
// led_ring_status_animator
// Renders one ring frame per animation tick: mode animations, pulse tables
// and a volume bar overlay, streamed out one pixel per cycle when not stalled.
// ----------------------------------------------------------------------------
module led_ring_status_animator #(
    parameter int RING_LEDS = lrsa_pkg::RING_LEDS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrsa_stream_if.sink   i_cfg,
    lrsa_stream_if.sink   i_tick,
    lrsa_stream_if.source o_pixel
);

    localparam int IDX_W   = lrsa_pkg::IDX_W;
    localparam int COLOR_W = lrsa_pkg::COLOR_W;
    localparam int LIT_W   = lrsa_pkg::LIT_W;
    localparam int PHASE_W = lrsa_pkg::PHASE_W;

    localparam logic [IDX_W-1:0]   LAST_IDX      = IDX_W'(RING_LEDS - 1);
    localparam logic [LIT_W-1:0]   RING_N        = LIT_W'(RING_LEDS);
    localparam logic [2:0]         BOOT_LAST     = 3'(lrsa_pkg::BOOT_STEP - 1);
    localparam logic [3:0]         ERROR_LAST    = 4'(lrsa_pkg::ERROR_STEP - 1);
    localparam logic [PHASE_W-1:0] STREAM_LAST   = PHASE_W'(lrsa_pkg::STREAM_PERIOD - 1);
    localparam logic [PHASE_W-1:0] WAKE_LAST     = PHASE_W'(lrsa_pkg::WAKE_PERIOD - 1);
    localparam logic [PHASE_W-1:0] SPEAK_LAST    = PHASE_W'(lrsa_pkg::SPEAK_PERIOD - 1);
    localparam logic [PHASE_W-1:0] CAPT_LAST     = PHASE_W'(lrsa_pkg::CAPT_PERIOD - 1);

    localparam lrsa_pkg::t_lit_rom    LIT_ROM    = lrsa_pkg::build_lit_rom(RING_LEDS);
    localparam lrsa_pkg::t_stream_rom STREAM_ROM = lrsa_pkg::build_stream_rom(RING_LEDS);

    typedef struct packed {
        logic                bar;
        logic [LIT_W-1:0]    lit;
        lrsa_pkg::t_mode     mode;
        logic [IDX_W-1:0]    center;
        logic [COLOR_W-1:0]  red;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
    } t_frame;

    typedef struct packed {
        logic [31:0]        frame;
        logic [PHASE_W-1:0] m80;
        logic [PHASE_W-1:0] m100;
        logic [PHASE_W-1:0] m120;
        logic [PHASE_W-1:0] m75;
        logic [2:0]         s6;
        logic [IDX_W-1:0]   pos;
        logic [3:0]         s10;
        logic               par;
    } t_phase;

    logic [lrsa_pkg::TICKS_W-1:0] r_ticks;
    logic [lrsa_pkg::TICKS_W-1:0] r_left, n_left;
    logic [lrsa_pkg::LEVEL_W-1:0] r_level, n_level;
    lrsa_pkg::t_mode              r_prev, n_prev;
    t_phase                       r_ph, n_ph;
    t_frame                       r_cur, n_cur;
    logic                         r_cur_v;
    logic [IDX_W-1:0]             r_pix;
    logic                         r_out_v;
    lrsa_pkg::t_pixel             r_out, n_out;

    lrsa_pkg::t_tick              tick;
    lrsa_pkg::t_mode              mode;
    logic [lrsa_pkg::TICKS_W-1:0] left_eff;
    t_phase                       ph;
    logic                         emit;
    logic                         last;
    logic                         accept;
    logic [LIT_W-1:0]             d_raw;
    logic [LIT_W-1:0]             d_fwd;
    logic [LIT_W-1:0]             d_back;
    logic [LIT_W-1:0]             gap;

    assign i_cfg.ready   = 1'b1;
    assign emit          = r_cur_v && (!r_out_v || o_pixel.ready);
    assign last          = (r_pix == LAST_IDX);
    assign i_tick.ready  = !r_cur_v || (emit && last);
    assign accept        = i_tick.valid && i_tick.ready;
    assign o_pixel.valid = r_out_v;
    assign o_pixel.payload = r_out;

    // tick update: overlay or animation, plus frame descriptor
    always_comb begin
        tick     = i_tick.payload;
        mode     = lrsa_pkg::t_mode'(tick.display_mode);
        n_level  = tick.volume_request ? tick.volume_percent : r_level;
        left_eff = tick.volume_request ? r_ticks : r_left;
        ph       = (mode != r_prev) ? '0 : r_ph;
        n_left   = left_eff;
        n_prev   = r_prev;
        n_ph     = r_ph;
        n_cur    = '0;
        n_cur.mode = mode;
        if (left_eff != '0) begin
            n_cur.bar = 1'b1;
            n_cur.lit = LIT_ROM[n_level];
            n_left    = left_eff - 1'b1;
        end else begin
            n_prev = mode;
            case (mode)
                lrsa_pkg::MODE_BOOT:    n_cur.center = ph.pos;
                lrsa_pkg::MODE_STREAM:  n_cur.center = STREAM_ROM[ph.m80];
                lrsa_pkg::MODE_WAKE:    n_cur.blue   = lrsa_pkg::WAKE_ROM[ph.m100];
                lrsa_pkg::MODE_SPEAK:   n_cur.green  = lrsa_pkg::SPEAK_ROM[ph.m120];
                lrsa_pkg::MODE_MUTE:    n_cur.red    = lrsa_pkg::MUTE_LEVEL;
                lrsa_pkg::MODE_ERROR:   n_cur.red    = ph.par ? '0 : lrsa_pkg::ERROR_LEVEL;
                lrsa_pkg::MODE_CAPTURE: begin
                    n_cur.red  = lrsa_pkg::CAPT_RED_ROM[ph.m75];
                    n_cur.blue = lrsa_pkg::CAPT_BLUE_ROM[ph.m75];
                end
                default: ;
            endcase
            // counter wrap returns every phase to zero
            if (ph.frame == '1) begin
                n_ph = '0;
            end else begin
                n_ph.frame = ph.frame + 32'd1;
                n_ph.m80   = (ph.m80 == STREAM_LAST) ? '0 : ph.m80 + 1'b1;
                n_ph.m100  = (ph.m100 == WAKE_LAST) ? '0 : ph.m100 + 1'b1;
                n_ph.m120  = (ph.m120 == SPEAK_LAST) ? '0 : ph.m120 + 1'b1;
                n_ph.m75   = (ph.m75 == CAPT_LAST) ? '0 : ph.m75 + 1'b1;
                n_ph.s6    = (ph.s6 == BOOT_LAST) ? '0 : ph.s6 + 1'b1;
                n_ph.pos   = ph.pos;
                if (ph.s6 == BOOT_LAST) begin
                    n_ph.pos = (ph.pos == LAST_IDX) ? '0 : ph.pos + 1'b1;
                end
                n_ph.s10   = (ph.s10 == ERROR_LAST) ? '0 : ph.s10 + 1'b1;
                n_ph.par   = (ph.s10 == ERROR_LAST) ? !ph.par : ph.par;
            end
        end
    end

    // pixel from frame descriptor
    always_comb begin
        d_raw  = {1'b0, r_pix} + RING_N - {1'b0, r_cur.center};
        d_fwd  = (d_raw >= RING_N) ? d_raw - RING_N : d_raw;
        d_back = RING_N - d_fwd;
        gap    = (d_fwd < d_back) ? d_fwd : d_back;
        n_out  = '0;
        n_out.pixel_index = r_pix;
        n_out.frame_last  = last;
        if (r_cur.bar) begin
            if ({1'b0, r_pix} < r_cur.lit) begin
                n_out.red   = lrsa_pkg::BAR_LEVEL;
                n_out.green = lrsa_pkg::BAR_LEVEL;
                n_out.blue  = lrsa_pkg::BAR_LEVEL;
            end
        end else if (r_cur.mode == lrsa_pkg::MODE_BOOT) begin
            case (gap)
                7'd0:    n_out.red = lrsa_pkg::BOOT_LEVEL_0;
                7'd1:    n_out.red = lrsa_pkg::BOOT_LEVEL_1;
                7'd2:    n_out.red = lrsa_pkg::BOOT_LEVEL_2;
                default: n_out.red = '0;
            endcase
            n_out.green = n_out.red;
            n_out.blue  = n_out.red;
        end else if (r_cur.mode == lrsa_pkg::MODE_STREAM) begin
            case (gap)
                7'd0:    n_out.blue = lrsa_pkg::STREAM_LEVEL_0;
                7'd1:    n_out.blue = lrsa_pkg::STREAM_LEVEL_1;
                7'd2:    n_out.blue = lrsa_pkg::STREAM_LEVEL_2;
                default: n_out.blue = '0;
            endcase
        end else begin
            n_out.red   = r_cur.red;
            n_out.green = r_cur.green;
            n_out.blue  = r_cur.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= lrsa_pkg::OVERLAY_TICKS_RESET;
            r_left  <= '0;
            r_level <= '0;
            r_prev  <= lrsa_pkg::MODE_BOOT;
            r_ph    <= '0;
            r_cur_v <= 1'b0;
            r_pix   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_ticks <= i_cfg.payload;
            end
            if (accept) begin
                r_left  <= n_left;
                r_level <= n_level;
                r_prev  <= n_prev;
                r_ph    <= n_ph;
                r_cur_v <= 1'b1;
            end else if (emit && last) begin
                r_cur_v <= 1'b0;
            end
            if (emit) begin
                r_pix   <= last ? '0 : r_pix + 1'b1;
                r_out_v <= 1'b1;
            end else if (o_pixel.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur <= n_cur;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (int'(r_out.pixel_index) < RING_LEDS))
        else $error("pixel index beyond ring");

    a_take_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_cur_v) |-> (emit && last))
        else $error("tick taken while frame still streaming");

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && o_pixel.ready && !r_out.frame_last) |=> r_out_v)
        else $error("frame broken before its last pixel");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ph.pos) < RING_LEDS)
        else $error("chaser position beyond ring");

endmodule
`default_nettype wire

[dv/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED ring status animator. Tick items are fed
// from a queue by a clocked driver, every accepted tick is rendered by an
// in-bench frame predictor, and each pixel leaving the block is compared
// field by field with the oldest pending pixel. The run walks through
// several overlay lengths and backpressure patterns, including one long
// output stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEDS = lrsa_pkg::RING_LEDS_DEFAULT;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lrsa_stream_if #(.T(lrsa_pkg::t_cfg))   cfg_if ();
    lrsa_stream_if #(.T(lrsa_pkg::t_tick))  tick_if ();
    lrsa_stream_if #(.T(lrsa_pkg::t_pixel)) pix_if ();

    led_ring_status_animator #(
        .RING_LEDS(LEDS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_tick  (tick_if),
        .o_pixel (pix_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted block state
    lrsa_pkg::t_cfg  overlay_ticks_cfg = lrsa_pkg::OVERLAY_TICKS_RESET;
    logic [31:0]     frame_count = '0;
    lrsa_pkg::t_mode last_mode = lrsa_pkg::MODE_BOOT;
    logic [6:0]      bar_left = '0;
    logic [7:0]      bar_level = '0;

    lrsa_pkg::t_tick  tick_pending[$];
    lrsa_pkg::t_pixel pixels_due[$];
    int     n_queued = 0;
    int     n_accepted = 0;
    int     n_errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_cycles = 0;
    logic   tick_taken = 1'b0;

    initial begin
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        tick_if.valid   = 1'b0;
        tick_if.payload = '0;
        pix_if.ready    = 1'b0;
    end

    function automatic logic [63:0] taylor_q30(logic [63:0] x, bit odd_series);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] b;
        longint      acc;
        x2  = (x * x) >> 30;
        t   = odd_series ? x : lrsa_pkg::Q30_ONE;
        acc = longint'(t);
        for (int n = 1; n <= 7; n++) begin
            a = odd_series ? 64'(2 * n) : 64'(2 * n - 1);
            b = odd_series ? 64'(2 * n + 1) : 64'(2 * n);
            t = ((t * x2) >> 30) / (a * b);
            if (n % 2 == 1) begin
                acc = acc - longint'(t);
            end else begin
                acc = acc + longint'(t);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(lrsa_pkg::Q30_ONE)) begin
            acc = longint'(lrsa_pkg::Q30_ONE);
        end
        return 64'(acc);
    endfunction

    function automatic longint sin_q30(int unsigned k, int unsigned p);
        int unsigned q;
        int unsigned quad;
        int unsigned r;
        bit          use_sin;
        longint      mag;
        q       = 4 * k;
        quad    = q / p;
        r       = q % p;
        use_sin = (quad % 2 == 0);
        if (r == 0) begin
            mag = use_sin ? 0 : longint'(lrsa_pkg::Q30_ONE);
        end else begin
            mag = longint'(taylor_q30(lrsa_pkg::HALF_PI_Q30 * 64'(r) / 64'(p), use_sin));
        end
        return (quad >= 2) ? -mag : mag;
    endfunction

    function automatic logic [7:0] pulse_value(int unsigned f, int unsigned a,
                                               int unsigned b, int unsigned p);
        longint s;
        longint v;
        s = sin_q30(f % p, p);
        v = (longint'(2 * a + b) <<< 30) + longint'(b) * s;
        if (v < 0) begin
            v = 0;
        end
        return 8'(v >>> 31);
    endfunction

    function automatic int unsigned ring_gap(int unsigned i, int unsigned c);
        int unsigned d;
        int unsigned e;
        d = (i + LEDS - c) % LEDS;
        e = LEDS - d;
        return (d < e) ? d : e;
    endfunction

    task automatic render_tick(input lrsa_pkg::t_tick tk);
        lrsa_pkg::t_mode  mode;
        bit               bar;
        int unsigned      lit;
        int unsigned      f;
        int unsigned      center;
        int unsigned      d;
        logic [7:0]       pr;
        logic [7:0]       pg;
        logic [7:0]       pb;
        logic [7:0]       lv;
        lrsa_pkg::t_pixel px;
        mode   = lrsa_pkg::t_mode'(tk.display_mode);
        bar    = 1'b0;
        lit    = 0;
        center = 0;
        pr     = '0;
        pg     = '0;
        pb     = '0;
        if (tk.volume_request) begin
            bar_level = tk.volume_percent;
            bar_left  = overlay_ticks_cfg;
        end
        if (bar_left != 0) begin
            bar = 1'b1;
            lit = (int'(bar_level) * LEDS + 50) / 100;
            if (lit > LEDS) begin
                lit = LEDS;
            end
            bar_left = bar_left - 1'b1;
        end else begin
            if (mode != last_mode) begin
                frame_count = '0;
                last_mode   = mode;
            end
            f           = frame_count;
            frame_count = frame_count + 1;
            case (mode)
                lrsa_pkg::MODE_BOOT:    center = (f / 6) % LEDS;
                lrsa_pkg::MODE_STREAM:  center = ((f % 80) * LEDS) / 80;
                lrsa_pkg::MODE_WAKE:    pb = pulse_value(f, 20, 60, 100);
                lrsa_pkg::MODE_SPEAK:   pg = pulse_value(f, 15, 55, 120);
                lrsa_pkg::MODE_MUTE:    pr = 8'd12;
                lrsa_pkg::MODE_ERROR:   pr = ((f / 10) % 2 == 0) ? 8'd80 : 8'd0;
                lrsa_pkg::MODE_CAPTURE: begin
                    pr = pulse_value(f, 5, 25, 75);
                    pb = pulse_value(f, 25, 35, 75);
                end
                default: ;
            endcase
        end
        for (int i = 0; i < LEDS; i++) begin
            px             = '0;
            px.pixel_index = lrsa_pkg::IDX_W'(i);
            px.frame_last  = (i == LEDS - 1);
            if (bar) begin
                if (i < lit) begin
                    px.red   = 8'd60;
                    px.green = 8'd60;
                    px.blue  = 8'd60;
                end
            end else begin
                case (mode)
                    lrsa_pkg::MODE_BOOT: begin
                        d  = ring_gap(i, center);
                        lv = (d == 0) ? 8'd80 : (d == 1) ? 8'd35 : (d == 2) ? 8'd10 : 8'd0;
                        px.red   = lv;
                        px.green = lv;
                        px.blue  = lv;
                    end
                    lrsa_pkg::MODE_STREAM: begin
                        d = ring_gap(i, center);
                        px.blue = (d == 0) ? 8'd60 : (d == 1) ? 8'd30 : (d == 2) ? 8'd10 : 8'd0;
                    end
                    default: begin
                        px.red   = pr;
                        px.green = pg;
                        px.blue  = pb;
                    end
                endcase
            end
            pixels_due.push_back(px);
        end
    endtask

    // tick driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else if (!tick_if.valid || tick_taken) begin
            if (tick_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                tick_if.valid   <= 1'b1;
                tick_if.payload <= tick_pending.pop_front();
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        tick_taken <= i_rst_n && tick_if.valid && tick_if.ready;
        if (i_rst_n && tick_if.valid && tick_if.ready) begin
            render_tick(tick_if.payload);
            n_accepted = n_accepted + 1;
        end
    end

    // pixel sink
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            pix_if.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            pix_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        lrsa_pkg::t_pixel want;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (pixels_due.size() == 0) begin
                $error("pixel item with no frame pending: index %0d",
                       pix_if.payload.pixel_index);
                n_errors = n_errors + 1;
            end else begin
                want = pixels_due.pop_front();
                if (pix_if.payload.pixel_index !== want.pixel_index) begin
                    $error("pixel_index: expected %0d, got %0d",
                           want.pixel_index, pix_if.payload.pixel_index);
                    n_errors = n_errors + 1;
                end
                if (pix_if.payload.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, pix_if.payload.red);
                    n_errors = n_errors + 1;
                end
                if (pix_if.payload.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, pix_if.payload.green);
                    n_errors = n_errors + 1;
                end
                if (pix_if.payload.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, pix_if.payload.blue);
                    n_errors = n_errors + 1;
                end
                if (pix_if.payload.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d",
                           want.frame_last, pix_if.payload.frame_last);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    task automatic push_tick(input lrsa_pkg::t_mode mode, input bit req, input int pct);
        lrsa_pkg::t_tick tk;
        tk.display_mode   = mode;
        tk.volume_request = req;
        tk.volume_percent = lrsa_pkg::LEVEL_W'(pct);
        tick_pending.push_back(tk);
        n_queued = n_queued + 1;
    endtask

    task automatic add_random_ticks(input int count);
        int              made;
        int              run;
        lrsa_pkg::t_mode mode;
        bit              req;
        int              pct;
        made = 0;
        while (made < count) begin
            mode = lrsa_pkg::t_mode'($urandom_range(7));
            run  = ($urandom_range(9) < 7) ? $urandom_range(1, 20) : $urandom_range(60, 160);
            for (int j = 0; j < run && made < count; j++) begin
                req = ($urandom_range(99) < 4);
                pct = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(110);
                push_tick(mode, req, pct);
                made = made + 1;
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (n_accepted != n_queued || pixels_due.size() != 0);
    endtask

    task automatic write_overlay_ticks(input lrsa_pkg::t_cfg value);
        @(negedge i_clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        overlay_ticks_cfg = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every mode, then overlay corner cases
        push_tick(lrsa_pkg::MODE_BOOT, 1'b0, 8'hFF);
        push_tick(lrsa_pkg::MODE_BOOT, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_IDLE, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_WAKE, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_WAKE, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_STREAM, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_SPEAK, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_MUTE, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_ERROR, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_CAPTURE, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_CAPTURE, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_WAKE, 1'b1, 255);
        push_tick(lrsa_pkg::MODE_WAKE, 1'b0, 0);
        wait_drained();
        write_overlay_ticks(7'd2);
        push_tick(lrsa_pkg::MODE_SPEAK, 1'b1, 0);
        push_tick(lrsa_pkg::MODE_SPEAK, 1'b1, 100);
        push_tick(lrsa_pkg::MODE_SPEAK, 1'b1, 2);
        push_tick(lrsa_pkg::MODE_SPEAK, 1'b1, 3);
        push_tick(lrsa_pkg::MODE_ERROR, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_ERROR, 1'b0, 0);
        push_tick(lrsa_pkg::MODE_CAPTURE, 1'b1, 101);
        push_tick(lrsa_pkg::MODE_CAPTURE, 1'b0, 50);
        push_tick(lrsa_pkg::MODE_CAPTURE, 1'b0, 0);
        wait_drained();
        write_overlay_ticks(7'd0);
        push_tick(lrsa_pkg::MODE_STREAM, 1'b1, 200);
        push_tick(lrsa_pkg::MODE_STREAM, 1'b0, 0);
        wait_drained();

        write_overlay_ticks(7'd1);
        add_random_ticks(90);
        wait_drained();

        write_overlay_ticks(7'd127);
        send_idle_pct = 63;
        add_random_ticks(90);
        wait_drained();

        write_overlay_ticks(lrsa_pkg::t_cfg'($urandom_range(2, 126)));
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        add_random_ticks(90);
        wait_drained();

        write_overlay_ticks(7'd0);
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        add_random_ticks(60);
        wait_drained();

        // long output stall while ticks keep coming
        write_overlay_ticks(7'd5);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        hold_cycles = 400;
        add_random_ticks(40);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
